### rtl/sas_pkg.sv
// ============================================================================
// sas_pkg - shared types and constants of the sprite animation sequencer
// Command codes, step table entry layout and timer unit operations.
// ============================================================================
package sas_pkg;

    // table geometry, fixed by the widths of the animation and step fields
    localparam int ANIM_W    = 4;
    localparam int STEP_W    = 6;
    localparam int MAX_ANIMS = 1 << ANIM_W;
    localparam int MAX_STEPS = 1 << STEP_W;
    localparam int SLOT_W    = ANIM_W + STEP_W;
    localparam int LEN_W     = STEP_W + 1;

    localparam int FRAME_W   = 9;
    localparam int TIME_W    = 16;
    localparam int TIMER_W   = 24;
    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    typedef enum logic [2:0] {
        CMD_TICK         = 3'd0,
        CMD_PLAY         = 3'd1,
        CMD_PLAY_FROM    = 3'd2,
        CMD_STOP         = 3'd3,
        CMD_SET_FRAME    = 3'd4,
        CMD_WRITE_STEP   = 3'd5,
        CMD_WRITE_HEADER = 3'd6
    } t_cmd;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [TIME_W-1:0]  delay;
    } t_step;

    typedef enum logic [1:0] {
        TU_ADD_SAT = 2'b01,
        TU_SUB     = 2'b10
    } t_tu_op;

endpackage

### rtl/sas_step_mem.sv
// ============================================================================
// sas_step_mem - step table storage
// Single port memory of frame and delay per step, registered read data.
// ============================================================================
module sas_step_mem (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [sas_pkg::SLOT_W-1:0] i_addr,
    input  sas_pkg::t_step            i_wdata,
    output sas_pkg::t_step            o_rdata
);

    localparam int DEPTH = sas_pkg::MAX_ANIMS * sas_pkg::MAX_STEPS;

    sas_pkg::t_step r_mem [DEPTH];
    sas_pkg::t_step r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sas_timer_unit.sv
// ============================================================================
// sas_timer_unit - shared timer arithmetic
// Saturating add of elapsed time, or subtract of a step delay with borrow.
// ============================================================================
module sas_timer_unit (
    input  sas_pkg::t_tu_op               i_op,
    input  logic [sas_pkg::TIMER_W-1:0]   i_a,
    input  logic [sas_pkg::TIMER_W-1:0]   i_b,
    output logic [sas_pkg::TIMER_W-1:0]   o_result,
    output logic                          o_borrow
);

    logic [sas_pkg::TIMER_W:0] w_sum;

    always_comb begin
        w_sum    = {1'b0, i_a} + {1'b0, i_b};
        o_result = w_sum[sas_pkg::TIMER_W-1:0];
        o_borrow = 1'b0;
        unique case (i_op)
            sas_pkg::TU_ADD_SAT: begin
                w_sum = {1'b0, i_a} + {1'b0, i_b};
                // clamp at the top of the timer range
                o_result = w_sum[sas_pkg::TIMER_W] ? sas_pkg::TIMER_MAX
                                                   : w_sum[sas_pkg::TIMER_W-1:0];
            end
            sas_pkg::TU_SUB: begin
                w_sum    = {1'b0, i_a} - {1'b0, i_b};
                o_result = w_sum[sas_pkg::TIMER_W-1:0];
                o_borrow = w_sum[sas_pkg::TIMER_W];
            end
            default: begin
                o_result = i_a;
            end
        endcase
    end

endmodule

### rtl/sprite_animation_sequencer.sv
// ============================================================================
// sprite_animation_sequencer - sprite frame animation player
// Step table, headers, playback state and a sequencer around a timer unit.
// ============================================================================
// Usage:
//   Requests enter on the s_axis channel: tuser carries the command, tdata the
//   operands. Every request gives exactly one result on m_axis: the shown
//   frame, step, animation, playing and finished flags, and a rejected flag
//   for an ignored set_frame. Registers rate and frame_count are written on
//   the cfg port while the block is idle.
//   Stop, set_frame, table writes, a play that changes nothing and a tick
//   while stopped or at rate zero go from the execute state straight to the
//   output state. A play that starts first reads its frame from the step
//   table. A tick adds time in the timer unit and, unless the step has zero
//   delay, walks steps: each step costs one compare/subtract in the timer
//   unit and, except a step that ends a one-shot animation, one step table
//   read. A single request is in work at a time; s_axis_tready is high only
//   while the sequencer is idle, so a new request is not taken before the
//   last one is through. The result sits in an output register, so the next
//   request is taken while it waits; that request then holds in the last
//   state until the output register frees up.
//   Reset clears playback state and headers and sets rate to 1.0; the step
//   table holds garbage until written and takes no clearing pass.
// ============================================================================
module sprite_animation_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // anim_id[3:0], step_index[9:4], frame_value[18:10], delay[34:19],
    // dt[50:35], restart[51], looping[52], length[59:53], zero[63:60]
    input  logic [63:0] s_axis_tdata,
    // command[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // shown_frame[8:0], current_step[14:9], current_anim[18:15],
    // is_playing[19], is_finished[20], rejected[21], zero[23:22]
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data
);

    localparam int AW = sas_pkg::ANIM_W;
    localparam int SW = sas_pkg::STEP_W;
    localparam int LW = sas_pkg::LEN_W;
    localparam int FW = sas_pkg::FRAME_W;
    localparam int TW = sas_pkg::TIME_W;
    localparam int RW = 12;
    localparam int PW = TW + RW;
    localparam int IW = PW - 8;

    localparam logic [1:0]    CFG_RATE        = 2'd0;
    localparam logic [1:0]    CFG_FRAME_COUNT = 2'd1;
    localparam logic [RW-1:0] RATE_RESET      = 12'd256;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_EXEC   = 7'b0000010,
        ST_T_ADD  = 7'b0000100,
        ST_T_CMP  = 7'b0001000,
        ST_T_LOAD = 7'b0010000,
        ST_P_LOAD = 7'b0100000,
        ST_OUT    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // request payload
    sas_pkg::t_cmd r_cmd;
    logic [AW-1:0] r_id;
    logic [SW-1:0] r_st;
    logic [FW-1:0] r_fv;
    logic [TW-1:0] r_dl;
    logic [TW-1:0] r_dt;
    logic          r_rs;
    logic          r_lp;
    logic [LW-1:0] r_ln;

    logic [RW-1:0] r_rate;
    logic [FW-1:0] r_frame_count;

    logic [LW-1:0] r_len   [sas_pkg::MAX_ANIMS];
    logic          r_loops [sas_pkg::MAX_ANIMS];

    logic [sas_pkg::TIMER_W-1:0] r_timer;
    logic [AW-1:0] r_cur_anim;
    logic [SW-1:0] r_cur_step;
    logic [FW-1:0] r_cur_frame;
    logic          r_playing;
    logic          r_finished;
    logic          r_rej;

    logic [IW-1:0] r_inc;
    logic [TW-1:0] r_delay;

    logic          r_out_valid;
    logic [23:0]   r_out_data;

    // memory and timer unit hookup
    logic                         w_mem_we;
    logic [sas_pkg::SLOT_W-1:0]   w_mem_addr;
    sas_pkg::t_step               w_mem_wdata;
    sas_pkg::t_step               w_rd;
    sas_pkg::t_tu_op              w_tu_op;
    logic [sas_pkg::TIMER_W-1:0]  w_tu_b;
    logic [sas_pkg::TIMER_W-1:0]  w_tu_result;
    logic                         w_tu_borrow;

    logic          w_accept;
    logic          w_out_free;
    logic [RW-1:0] w_mag;
    logic [PW-1:0] w_prod;
    logic          w_play_go;
    logic          w_pfs_go;
    logic          w_bad_frame;
    logic [LW-1:0] w_len;
    logic          w_lp;
    logic          w_at_end;
    logic [SW-1:0] w_next;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_mag  = r_rate[RW-1] ? (~r_rate + 1'b1) : r_rate;
    assign w_prod = PW'(r_dt) * PW'(w_mag);

    assign w_play_go = r_rs || (!r_playing && !r_finished) || (r_cur_anim != r_id);
    assign w_pfs_go  = !r_playing || (r_cur_anim != r_id) || r_rs;

    assign w_bad_frame = ($signed({r_fv[FW-1], r_fv}) < -10'sd1) ||
                         ($signed({r_fv[FW-1], r_fv}) >= $signed({1'b0, r_frame_count}));

    assign w_len = r_len[r_cur_anim];
    assign w_lp  = r_loops[r_cur_anim];

    // next step of the walk, forward for positive rate and backward otherwise
    always_comb begin
        if (!r_rate[RW-1]) begin
            w_at_end = ({1'b0, r_cur_step} + 1'b1) >= w_len;
            w_next   = w_at_end ? '0 : r_cur_step + 1'b1;
        end else begin
            w_at_end = (r_cur_step == '0);
            if (!w_at_end) begin
                w_next = r_cur_step - 1'b1;
            end else if (w_len == '0) begin
                w_next = '0;
            end else begin
                w_next = SW'(w_len - 1'b1);
            end
        end
    end

    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_addr  = {r_cur_anim, r_cur_step};
        w_mem_wdata = '{frame: r_fv, delay: r_dl};
        if (r_state == ST_EXEC) begin
            case (r_cmd)
                sas_pkg::CMD_PLAY:       w_mem_addr = {r_id, {SW{1'b0}}};
                sas_pkg::CMD_PLAY_FROM:  w_mem_addr = {r_id, r_st};
                sas_pkg::CMD_WRITE_STEP: begin
                    w_mem_addr = {r_id, r_st};
                    w_mem_we   = 1'b1;
                end
                default:                 w_mem_addr = {r_cur_anim, r_cur_step};
            endcase
        end else if (r_state == ST_T_CMP) begin
            w_mem_addr = {r_cur_anim, w_next};
        end
    end

    assign w_tu_op = (r_state == ST_T_ADD) ? sas_pkg::TU_ADD_SAT : sas_pkg::TU_SUB;
    assign w_tu_b  = (r_state == ST_T_ADD) ? sas_pkg::TIMER_W'(r_inc)
                                           : sas_pkg::TIMER_W'(r_delay);

    sas_step_mem u_step_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_rd)
    );

    sas_timer_unit u_timer_unit (
        .i_op     (w_tu_op),
        .i_a      (r_timer),
        .i_b      (w_tu_b),
        .o_result (w_tu_result),
        .o_borrow (w_tu_borrow)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                case (r_cmd)
                    sas_pkg::CMD_TICK:
                        n_state = (r_playing && r_rate != '0) ? ST_T_ADD : ST_OUT;
                    sas_pkg::CMD_PLAY:
                        n_state = w_play_go ? ST_P_LOAD : ST_OUT;
                    sas_pkg::CMD_PLAY_FROM:
                        n_state = w_pfs_go ? ST_P_LOAD : ST_OUT;
                    default:
                        n_state = ST_OUT;
                endcase
            end
            ST_T_ADD: begin
                n_state = (w_rd.delay == '0) ? ST_OUT : ST_T_CMP;
            end
            ST_T_CMP: begin
                if (r_delay == '0 || w_tu_borrow || (w_at_end && !w_lp)) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_T_LOAD;
                end
            end
            ST_T_LOAD: n_state = ST_T_CMP;
            ST_P_LOAD: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // request payload and walk scratch registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= sas_pkg::t_cmd'(s_axis_tuser);
            r_id  <= s_axis_tdata[3:0];
            r_st  <= s_axis_tdata[9:4];
            r_fv  <= s_axis_tdata[18:10];
            r_dl  <= s_axis_tdata[34:19];
            r_dt  <= s_axis_tdata[50:35];
            r_rs  <= s_axis_tdata[51];
            r_lp  <= s_axis_tdata[52];
            r_ln  <= s_axis_tdata[59:53];
        end
        if (r_state == ST_EXEC) begin
            r_inc <= w_prod[PW-1:8];
        end
        if (r_state == ST_T_ADD || r_state == ST_T_LOAD) begin
            r_delay <= w_rd.delay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_rate        <= RATE_RESET;
            r_frame_count <= '0;
            for (int i = 0; i < sas_pkg::MAX_ANIMS; i++) begin
                r_len[i]   <= '0;
                r_loops[i] <= 1'b0;
            end
            r_timer     <= '0;
            r_cur_anim  <= '0;
            r_cur_step  <= '0;
            r_cur_frame <= '0;
            r_playing   <= 1'b0;
            r_finished  <= 1'b0;
            r_rej       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_data  <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_RATE:        r_rate        <= i_cfg_data;
                    CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[FW-1:0];
                    default: ;
                endcase
            end

            // load a result when the register frees up, drop it once taken
            if (r_state == ST_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_EXEC: begin
                    r_rej <= (r_cmd == sas_pkg::CMD_SET_FRAME) && w_bad_frame;
                    case (r_cmd)
                        sas_pkg::CMD_PLAY: begin
                            if (w_play_go) begin
                                r_cur_anim <= r_id;
                                r_cur_step <= '0;
                                r_timer    <= '0;
                                r_finished <= 1'b0;
                                r_playing  <= 1'b1;
                            end
                        end
                        sas_pkg::CMD_PLAY_FROM: begin
                            if (w_pfs_go) begin
                                r_cur_anim <= r_id;
                                r_cur_step <= r_st;
                                r_timer    <= '0;
                                r_finished <= 1'b0;
                                r_playing  <= 1'b1;
                            end
                        end
                        sas_pkg::CMD_STOP: begin
                            r_cur_step <= '0;
                            r_playing  <= 1'b0;
                            r_finished <= 1'b0;
                        end
                        sas_pkg::CMD_SET_FRAME: begin
                            if (!w_bad_frame) begin
                                if (r_playing) begin
                                    r_cur_step <= '0;
                                    r_playing  <= 1'b0;
                                    r_finished <= 1'b0;
                                end
                                r_cur_frame <= r_fv;
                            end
                        end
                        sas_pkg::CMD_WRITE_HEADER: begin
                            r_len[r_id]   <= (r_ln > LW'(sas_pkg::MAX_STEPS))
                                             ? LW'(sas_pkg::MAX_STEPS) : r_ln;
                            r_loops[r_id] <= r_lp;
                        end
                        default: ;
                    endcase
                end
                ST_T_ADD: begin
                    if (w_rd.delay != '0) begin
                        r_timer <= w_tu_result;
                    end
                end
                ST_T_CMP: begin
                    // advance one step while the timer covers the delay
                    if (r_delay != '0 && !w_tu_borrow) begin
                        r_timer    <= w_tu_result;
                        r_cur_step <= w_next;
                        if (w_at_end && !w_lp) begin
                            r_finished <= 1'b1;
                            r_playing  <= 1'b0;
                        end
                    end
                end
                ST_T_LOAD: begin
                    r_cur_frame <= w_rd.frame;
                end
                ST_P_LOAD: begin
                    r_cur_frame <= w_rd.frame;
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_out_data  <= {2'b00, r_rej, r_finished, r_playing,
                                        r_cur_anim, r_cur_step, r_cur_frame};
                    end
                end
                default: ;
            endcase
        end
    end

    a_play_fin_excl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_playing && r_finished))
        else $error("playing and finished set together");

    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("request taken while a request is in work");

    a_out_from_last_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_OUT))
        else $error("result loaded outside the output state");

endmodule

### tb/sv/sprite_animation_sequencer_test.sv
`timescale 1ns / 100ps
// ============================================================================
// sprite_animation_sequencer_test - self-checking bench of the animation player
// Commands go in on s_axis from a queue of pending requests. A behavioral
// shadow of the player predicts the frame, step, animation and flags that
// each request leaves behind. Results on m_axis are checked field by field,
// in order. Both sides stall at random, except in the second phase. Rate
// and frame count are changed between phases, while the player is idle.
// ============================================================================
module sprite_animation_sequencer_test;

    localparam logic [2:0] CMD_UNKNOWN     = 3'd7;
    localparam logic [1:0] REG_RATE        = 2'd0;
    localparam logic [1:0] REG_FRAME_COUNT = 2'd1;
    localparam int WALK_CAP     = 48;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 400;
    localparam int PHASES       = 7;

    typedef struct {
        logic [2:0]  cmd;
        logic [3:0]  anim;
        logic [5:0]  step;
        logic [8:0]  frame;
        logic [15:0] delay;
        logic [15:0] dt;
        logic        restart;
        logic        looping;
        logic [6:0]  length;
    } t_anim_req;

    typedef struct {
        logic [8:0] frame;
        logic [5:0] step;
        logic [3:0] anim;
        logic       playing;
        logic       finished;
        logic       rejected;
    } t_anim_view;

    typedef struct {
        logic [23:0] timer;
        logic [3:0]  anim;
        logic [5:0]  step;
        logic [8:0]  frame;
        logic        playing;
        logic        finished;
    } t_player;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // anim_id, step_index, frame_value, delay, dt, restart, looping, length, zero
    logic [63:0] s_axis_tdata = '0;
    // command
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // shown_frame, current_step, current_anim, is_playing, is_finished,
    // rejected, zero
    logic [23:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [11:0] i_cfg_data = '0;

    sprite_animation_sequencer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // shadow of the player
    logic [8:0]  shadow_frame   [sas_pkg::MAX_ANIMS*sas_pkg::MAX_STEPS];
    logic [15:0] shadow_delay   [sas_pkg::MAX_ANIMS*sas_pkg::MAX_STEPS];
    bit          shadow_written [sas_pkg::MAX_ANIMS*sas_pkg::MAX_STEPS];
    logic [6:0]  shadow_len     [sas_pkg::MAX_ANIMS];
    bit          shadow_loops   [sas_pkg::MAX_ANIMS];
    t_player     player;
    logic signed [11:0] rate_q;
    logic [8:0]  frame_limit;
    bit          stray_read;
    int          walk_len;

    t_anim_req   pending_requests [$];
    t_anim_view  expected_views [$];
    int          accepted_items = 0;
    int          mismatches = 0;
    int          idle_pct = 35;
    int          stall_cycles = 0;

    t_anim_req   next_req;
    t_anim_view  seen_view;
    t_anim_view  wanted_view;

    int phase_rate   [PHASES] = '{256, 2047, -2048, -256, 0, 1, -37};
    int phase_frames [PHASES] = '{0, 256, 1, 100, 17, 255, 200};

    // flag any read of a step entry that was never written
    function automatic logic [8:0] table_frame(logic [3:0] a, logic [5:0] s);
        if (!shadow_written[{a, s}]) stray_read = 1'b1;
        return shadow_frame[{a, s}];
    endfunction

    function automatic logic [15:0] table_delay(logic [3:0] a, logic [5:0] s);
        if (!shadow_written[{a, s}]) stray_read = 1'b1;
        return shadow_delay[{a, s}];
    endfunction

    function automatic void start_anim(logic [3:0] id);
        player.anim     = id;
        player.step     = '0;
        player.frame    = table_frame(id, 6'd0);
        player.timer    = '0;
        player.finished = 1'b0;
        player.playing  = 1'b1;
    endfunction

    function automatic void halt_anim();
        player.step     = '0;
        player.playing  = 1'b0;
        player.finished = 1'b0;
    endfunction

    function automatic void advance_time(logic [15:0] dt);
        int          r;
        int unsigned mag;
        int unsigned t;
        logic [15:0] d;
        logic [6:0]  len;
        logic [5:0]  nxt;
        bit          wrapped;
        r = rate_q;
        if (!player.playing || r == 0) return;
        if (table_delay(player.anim, player.step) == 0) return;
        mag = (r < 0) ? -r : r;
        t = player.timer + ((dt * mag) >> 8);
        if (t > 32'hFFFFFF) t = 32'hFFFFFF;
        while (player.playing) begin
            d = table_delay(player.anim, player.step);
            len = shadow_len[player.anim];
            if (d == 0 || t < d) break;
            t -= d;
            walk_len++;
            if (walk_len > WALK_CAP) break;
            wrapped = 1'b0;
            if (r > 0) begin
                if (player.step + 1 >= len) begin
                    nxt = '0;
                    wrapped = 1'b1;
                end else begin
                    player.step = player.step + 1'b1;
                end
            end else begin
                if (player.step == 0) begin
                    nxt = (len == 0) ? 6'd0 : 6'(len - 1);
                    wrapped = 1'b1;
                end else begin
                    player.step = player.step - 1'b1;
                end
            end
            if (wrapped) begin
                player.step = nxt;
                if (shadow_loops[player.anim]) begin
                    player.frame = table_frame(player.anim, nxt);
                end else begin
                    player.finished = 1'b1;
                    player.playing  = 1'b0;
                end
            end
            if (player.playing) player.frame = table_frame(player.anim, player.step);
        end
        player.timer = t[23:0];
    endfunction

    function automatic t_anim_view apply_command(t_anim_req q);
        t_anim_view v;
        logic       rej;
        int         f;
        rej = 1'b0;
        case (q.cmd)
            sas_pkg::CMD_TICK: advance_time(q.dt);
            sas_pkg::CMD_PLAY: begin
                if (q.restart || (!player.playing && !player.finished) ||
                    player.anim != q.anim)
                    start_anim(q.anim);
            end
            sas_pkg::CMD_PLAY_FROM: begin
                if (!player.playing || player.anim != q.anim || q.restart) begin
                    start_anim(q.anim);
                    player.step  = q.step;
                    player.frame = table_frame(q.anim, q.step);
                end
            end
            sas_pkg::CMD_STOP: halt_anim();
            sas_pkg::CMD_SET_FRAME: begin
                f = $signed(q.frame);
                if (f < -1 || f >= int'(frame_limit)) begin
                    rej = 1'b1;
                end else begin
                    if (player.playing) halt_anim();
                    player.frame = q.frame;
                end
            end
            sas_pkg::CMD_WRITE_STEP: begin
                shadow_frame[{q.anim, q.step}]   = q.frame;
                shadow_delay[{q.anim, q.step}]   = q.delay;
                shadow_written[{q.anim, q.step}] = 1'b1;
            end
            sas_pkg::CMD_WRITE_HEADER: begin
                shadow_len[q.anim]   = (q.length > sas_pkg::MAX_STEPS)
                                       ? 7'(sas_pkg::MAX_STEPS) : q.length;
                shadow_loops[q.anim] = q.looping;
            end
            default: ;
        endcase
        v.frame    = player.frame;
        v.step     = player.step;
        v.anim     = player.anim;
        v.playing  = player.playing;
        v.finished = player.finished;
        v.rejected = rej;
        return v;
    endfunction

    // Queue a request unless it would read an unwritten step or walk too far.
    // A tick that is refused for either reason is retried with a shorter dt.
    function automatic bit offer(t_anim_req q);
        t_player    saved;
        t_anim_view v;
        bit         taken;
        forever begin
            saved = player;
            stray_read = 1'b0;
            walk_len = 0;
            v = apply_command(q);
            taken = !stray_read && walk_len <= WALK_CAP;
            if (taken) begin
                pending_requests.push_back(q);
                expected_views.push_back(v);
                accepted_items++;
                break;
            end
            player = saved;
            if (q.cmd != sas_pkg::CMD_TICK || q.dt == 0) break;
            q.dt = q.dt >> 1;
        end
        return taken;
    endfunction

    function automatic void directed(logic [2:0] cmd, logic [3:0] anim, logic [5:0] step,
                                     logic [8:0] frame, logic [15:0] delay, logic [15:0] dt,
                                     logic restart, logic looping, logic [6:0] length);
        t_anim_req q;
        q = '{cmd, anim, step, frame, delay, dt, restart, looping, length};
        void'(offer(q));
    endfunction

    function automatic t_anim_req rand_req();
        t_anim_req q;
        q.cmd     = sas_pkg::CMD_TICK;
        q.anim    = 4'($urandom);
        q.step    = 6'($urandom);
        q.frame   = 9'($urandom_range(0, 256) - 1);
        q.delay   = 16'($urandom);
        q.dt      = 16'($urandom);
        q.restart = 1'($urandom);
        q.looping = 1'($urandom);
        q.length  = 7'($urandom_range(0, 64));
        return q;
    endfunction

    function automatic logic [15:0] rand_delay();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return 16'd0;
        if (pick < 15) return 16'hFFFF;
        if (pick < 25) return 16'($urandom_range(1, 15));
        return 16'($urandom_range(32, 1023));
    endfunction

    function automatic logic [15:0] rand_dt();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return 16'd0;
        if (pick < 20) return 16'hFFFF;
        if (pick < 40) return 16'($urandom);
        return 16'($urandom_range(0, 1023));
    endfunction

    // Build an animation, start it, then mostly tick with some noise mixed in.
    function automatic void run_episode();
        t_anim_req q;
        int        a;
        int        len;
        int        span;
        int        pick;
        int        n;
        a = $urandom_range(0, sas_pkg::MAX_ANIMS - 1);
        pick = $urandom_range(0, 99);
        if (pick < 10) len = 0;
        else if (pick < 80) len = $urandom_range(1, 6);
        else if (pick < 95) len = $urandom_range(7, 16);
        else len = sas_pkg::MAX_STEPS;
        span = len + $urandom_range(0, 2);
        if (span == 0) span = 1;
        if (span > sas_pkg::MAX_STEPS) span = sas_pkg::MAX_STEPS;
        for (int s = 0; s < span; s++) begin
            q = rand_req();
            q.cmd   = sas_pkg::CMD_WRITE_STEP;
            q.anim  = 4'(a);
            q.step  = 6'(s);
            q.frame = ($urandom_range(0, 9) == 0) ? 9'h1FF : 9'($urandom_range(0, 255));
            q.delay = rand_delay();
            void'(offer(q));
        end
        q = rand_req();
        q.cmd    = sas_pkg::CMD_WRITE_HEADER;
        q.anim   = 4'(a);
        q.length = 7'(len);
        void'(offer(q));
        q = rand_req();
        q.anim = 4'(a);
        if ($urandom_range(0, 3) == 0) begin
            q.cmd  = sas_pkg::CMD_PLAY_FROM;
            q.step = 6'($urandom_range(0, span - 1));
        end else begin
            q.cmd = sas_pkg::CMD_PLAY;
        end
        void'(offer(q));
        n = $urandom_range(4, 12);
        repeat (n) begin
            q = rand_req();
            if ($urandom_range(0, 99) < 65) begin
                q.cmd = sas_pkg::CMD_TICK;
                q.dt  = rand_dt();
            end else begin
                q.cmd = 3'($urandom_range(1, 7));
                if (q.cmd == sas_pkg::CMD_SET_FRAME) begin
                    case ($urandom_range(0, 4))
                        0: q.frame = 9'($urandom);
                        1: q.frame = frame_limit - 1'b1;
                        2: q.frame = frame_limit;
                        3: q.frame = 9'h1FF;
                        default: q.frame = 9'h1FE;
                    endcase
                end
            end
            void'(offer(q));
        end
    endfunction

    task automatic drain();
        while (pending_requests.size() != 0 || expected_views.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= 12'(value);
        @(posedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                next_req = pending_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'b0, next_req.length, next_req.looping, next_req.restart,
                                  next_req.dt, next_req.delay, next_req.frame, next_req.step,
                                  next_req.anim};
                s_axis_tuser  <= next_req.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_view.frame    = m_axis_tdata[8:0];
            seen_view.step     = m_axis_tdata[14:9];
            seen_view.anim     = m_axis_tdata[18:15];
            seen_view.playing  = m_axis_tdata[19];
            seen_view.finished = m_axis_tdata[20];
            seen_view.rejected = m_axis_tdata[21];
            if (expected_views.size() == 0) begin
                $error("result with no request outstanding: %h", m_axis_tdata);
                mismatches++;
            end else begin
                wanted_view = expected_views.pop_front();
                if (seen_view.frame !== wanted_view.frame) begin
                    $error("shown_frame: expected %0d, got %0d",
                           $signed(wanted_view.frame), $signed(seen_view.frame));
                    mismatches++;
                end
                if (seen_view.step !== wanted_view.step) begin
                    $error("current_step: expected %0d, got %0d",
                           wanted_view.step, seen_view.step);
                    mismatches++;
                end
                if (seen_view.anim !== wanted_view.anim) begin
                    $error("current_anim: expected %0d, got %0d",
                           wanted_view.anim, seen_view.anim);
                    mismatches++;
                end
                if (seen_view.playing !== wanted_view.playing) begin
                    $error("is_playing: expected %0b, got %0b",
                           wanted_view.playing, seen_view.playing);
                    mismatches++;
                end
                if (seen_view.finished !== wanted_view.finished) begin
                    $error("is_finished: expected %0b, got %0b",
                           wanted_view.finished, seen_view.finished);
                    mismatches++;
                end
                if (seen_view.rejected !== wanted_view.rejected) begin
                    $error("rejected: expected %0b, got %0b",
                           wanted_view.rejected, seen_view.rejected);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int goal;
        player = '{default: '0};
        foreach (shadow_len[i]) begin
            shadow_len[i]   = '0;
            shadow_loops[i] = 1'b0;
        end
        rate_q = 12'sd256;
        frame_limit = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // looping animation 0: extremes of frame and delay, wrap forward
        directed(sas_pkg::CMD_WRITE_HEADER, 0, 0, 0, 0, 0, 0, 1, 3);
        directed(sas_pkg::CMD_WRITE_STEP, 0, 0, 9'h1FF, 256, 0, 0, 0, 0);
        directed(sas_pkg::CMD_WRITE_STEP, 0, 1, 255, 16'hFFFF, 0, 0, 0, 0);
        directed(sas_pkg::CMD_WRITE_STEP, 0, 2, 0, 1, 0, 0, 0, 0);
        directed(CMD_UNKNOWN, 15, 63, 9'h1FF, 16'hFFFF, 16'hFFFF, 1, 1, 64);
        directed(sas_pkg::CMD_PLAY, 0, 0, 0, 0, 0, 0, 0, 0);
        directed(sas_pkg::CMD_TICK, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0);
        directed(sas_pkg::CMD_TICK, 0, 0, 0, 0, 256, 0, 0, 0);
        directed(sas_pkg::CMD_TICK, 0, 0, 0, 0, 1, 0, 0, 0);
        directed(sas_pkg::CMD_PLAY, 0, 0, 0, 0, 0, 0, 0, 0);
        directed(sas_pkg::CMD_PLAY, 0, 0, 0, 0, 0, 1, 0, 0);
        // zero-delay step outside the length, reached by play_from
        directed(sas_pkg::CMD_WRITE_STEP, 0, 3, 7, 0, 0, 0, 0, 0);
        directed(sas_pkg::CMD_PLAY_FROM, 0, 3, 0, 0, 0, 1, 0, 0);
        directed(sas_pkg::CMD_TICK, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0);
        // set_frame bounds with no frames defined
        directed(sas_pkg::CMD_SET_FRAME, 0, 0, 0, 0, 0, 0, 0, 0);
        directed(sas_pkg::CMD_SET_FRAME, 0, 0, 9'h1FF, 0, 0, 0, 0, 0);
        directed(sas_pkg::CMD_SET_FRAME, 0, 0, 9'h100, 0, 0, 0, 0, 0);
        // oversized header saturates, then a short one-shot animation
        directed(sas_pkg::CMD_WRITE_HEADER, 15, 0, 0, 0, 0, 0, 0, 100);
        directed(sas_pkg::CMD_WRITE_HEADER, 15, 0, 0, 0, 0, 0, 0, 2);
        directed(sas_pkg::CMD_WRITE_STEP, 15, 0, 9'h0AA, 128, 0, 0, 0, 0);
        directed(sas_pkg::CMD_WRITE_STEP, 15, 1, 9'h055, 128, 0, 0, 0, 0);
        directed(sas_pkg::CMD_PLAY, 15, 0, 0, 0, 0, 0, 0, 0);
        directed(sas_pkg::CMD_TICK, 0, 0, 0, 0, 512, 0, 0, 0);
        directed(sas_pkg::CMD_PLAY, 15, 0, 0, 0, 0, 0, 0, 0);
        directed(sas_pkg::CMD_STOP, 0, 0, 0, 0, 0, 0, 0, 0);
        directed(sas_pkg::CMD_WRITE_STEP, 15, 63, 3, 5, 0, 0, 0, 0);
        directed(sas_pkg::CMD_PLAY_FROM, 15, 63, 0, 0, 0, 0, 0, 0);

        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                // hold the sender until the player is idle, then reconfigure
                drain();
                @(posedge i_clk);
                write_reg(REG_RATE, phase_rate[p]);
                write_reg(REG_FRAME_COUNT, phase_frames[p]);
                i_cfg_we <= 1'b0;
                rate_q = 12'(phase_rate[p]);
                frame_limit = 9'(phase_frames[p]);
                @(negedge i_clk);
            end
            idle_pct = (p == 1) ? 0 : 35;
            goal = accepted_items + RANDOM_ITEMS / PHASES;
            while (accepted_items < goal) run_episode();
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sprite_animation_sequencer.f
rtl/sas_pkg.sv
rtl/sas_step_mem.sv
rtl/sas_timer_unit.sv
rtl/sprite_animation_sequencer.sv
tb/sv/sprite_animation_sequencer_test.sv
